/* hw/rtl/tsn_pkg.sv */
// shared constants, result type and reply decode for the telnet stream negotiator
`default_nettype none
package tsn_pkg;

  localparam logic [7:0] IAC  = 8'hFF;
  localparam logic [7:0] DONT = 8'hFE;
  localparam logic [7:0] DO   = 8'hFD;
  localparam logic [7:0] WONT = 8'hFC;
  localparam logic [7:0] WILL = 8'hFB;
  localparam logic [7:0] SB   = 8'hFA;
  localparam logic [7:0] GA   = 8'hF9;
  localparam logic [7:0] NOP  = 8'hF1;
  localparam logic [7:0] SE   = 8'hF0;

  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_NAWS   = 8'd31;

  localparam logic [1:0] KIND_DISPLAY = 2'd0;
  localparam logic [1:0] KIND_REPLY   = 2'd1;
  localparam logic [1:0] KIND_NAWS    = 2'd2;
  localparam logic [1:0] KIND_TTYPE   = 2'd3;

  localparam int TDATA_W = 32;

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
    logic [7:0] display;
    logic [7:0] verb;
    logic [7:0] option;
    logic       echo;
  } result_t;

  // reply for a completed command or subnegotiation
  function automatic result_t answer(input logic [7:0] verb, input logic [7:0] opt,
                                     input logic echo);
    result_t r;
    r = '0;
    r.echo = echo;
    case (verb)
      DO: begin
        r.hit = 1'b1;
        if (opt == OPT_NAWS) begin
          r.kind = KIND_NAWS;
        end else begin
          r.kind   = KIND_REPLY;
          r.option = opt;
          r.verb   = (opt == OPT_TTYPE || opt == OPT_BINARY) ? WILL : WONT;
        end
      end
      WILL: begin
        r.hit    = 1'b1;
        r.kind   = KIND_REPLY;
        r.verb   = DO;
        r.option = opt;
        if (opt == OPT_ECHO) r.echo = 1'b0;
      end
      WONT: begin
        r.hit    = 1'b1;
        r.kind   = KIND_REPLY;
        r.verb   = DONT;
        r.option = opt;
        if (opt == OPT_ECHO) r.echo = 1'b1;
      end
      DONT: begin
        r.hit    = 1'b1;
        r.kind   = KIND_REPLY;
        r.verb   = WONT;
        r.option = opt;
      end
      SB: begin
        if (opt == OPT_TTYPE) begin
          r.hit  = 1'b1;
          r.kind = KIND_TTYPE;
        end
      end
      default: begin
        r.hit = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/tsn_core.sv */
// parser state and per-byte decode of the telnet command stream
`default_nettype none
module tsn_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      rx_byte,
  output tsn_pkg::result_t     res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_SUB  = 2'd2,
    PH_WAIT = 2'd3
  } phase_t;

  phase_t     phase, phase_next;
  logic [1:0] cnt, cnt_next;
  logic [7:0] held_verb, held_verb_next;
  logic [7:0] held_option, held_option_next;
  logic       local_echo, local_echo_next;

  always_comb begin
    phase_next       = phase;
    cnt_next         = cnt;
    held_verb_next   = held_verb;
    held_option_next = held_option;
    res              = '0;
    res.echo         = local_echo;
    case (phase)
      PH_IDLE: begin
        if (rx_byte == tsn_pkg::IAC) begin
          phase_next = PH_CMD;
          cnt_next   = 2'd1;
        end else begin
          res.hit     = 1'b1;
          res.kind    = tsn_pkg::KIND_DISPLAY;
          res.display = rx_byte;
        end
      end
      PH_CMD: begin
        if (cnt == 2'd1) begin
          held_verb_next = rx_byte;
          if (rx_byte == tsn_pkg::IAC) begin
            phase_next  = PH_IDLE;
            res.hit     = 1'b1;
            res.kind    = tsn_pkg::KIND_DISPLAY;
            res.display = tsn_pkg::IAC;
          end else if (rx_byte inside {[tsn_pkg::NOP:tsn_pkg::GA]}) begin
            phase_next = PH_IDLE;
          end else if (rx_byte == tsn_pkg::SB) begin
            phase_next = PH_SUB;
            cnt_next   = 2'd2;
          end else begin
            cnt_next = 2'd2;
          end
        end else begin
          // option byte completes the command
          held_option_next = rx_byte;
          cnt_next         = 2'd3;
          phase_next       = PH_IDLE;
          res              = tsn_pkg::answer(held_verb, rx_byte, local_echo);
        end
      end
      PH_SUB: begin
        if (cnt == 2'd2) held_option_next = rx_byte;
        if (cnt != 2'd3) cnt_next = cnt + 2'd1;
        if (rx_byte == tsn_pkg::IAC) phase_next = PH_WAIT;
      end
      PH_WAIT: begin
        if (rx_byte == tsn_pkg::SE) begin
          phase_next = PH_IDLE;
          res        = tsn_pkg::answer(held_verb, held_option, local_echo);
        end else begin
          // stray iac inside the body: drop it and keep going
          if (cnt != 2'd3) cnt_next = cnt + 2'd1;
          phase_next = PH_SUB;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    local_echo_next = res.echo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      cnt         <= 2'd1;
      held_verb   <= '0;
      held_option <= '0;
      local_echo  <= 1'b1;
    end else if (step) begin
      phase       <= phase_next;
      cnt         <= cnt_next;
      held_verb   <= held_verb_next;
      held_option <= held_option_next;
      local_echo  <= local_echo_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/telnet_stream_negotiator_unit.sv */
// telnet stream negotiator top level: byte intake, parser and result register
// a result word is registered and appears on m_tvalid in the cycle after its byte is taken
// throughput: one byte per cycle while no word is stalled; the parser state is registered on each byte taken
// a byte that yields no result leaves no word; s_tready drops only while a word is stalled
// reset: synchronous; parser idle, local echo set, no word pending
`default_nettype none
module telnet_stream_negotiator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // rx_byte
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // display_byte, reply_verb, reply_option, echo_local, zero fill
  output logic [tsn_pkg::TDATA_W-1:0]        m_tdata,
  output logic [1:0]                         m_tuser    // result_kind
);

  tsn_pkg::result_t res;
  logic             accept;

  logic [1:0] out_kind;
  logic [7:0] out_display;
  logic [7:0] out_verb;
  logic [7:0] out_option;
  logic       out_echo;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  tsn_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .rx_byte (s_tdata),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= accept && res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.hit) begin
      out_kind    <= res.kind;
      out_display <= res.display;
      out_verb    <= res.verb;
      out_option  <= res.option;
      out_echo    <= res.echo;
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {7'd0, out_echo, out_option, out_verb, out_display};

  a_display_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_kind != tsn_pkg::KIND_DISPLAY |-> out_display == 8'd0)
    else $error("display byte set on a non-display word");

  a_reply_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_kind != tsn_pkg::KIND_REPLY |-> out_verb == 8'd0 && out_option == 8'd0)
    else $error("reply fields set on a non-reply word");

  a_reply_verb: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_kind == tsn_pkg::KIND_REPLY |->
      out_verb == tsn_pkg::WILL || out_verb == tsn_pkg::WONT ||
      out_verb == tsn_pkg::DO || out_verb == tsn_pkg::DONT)
    else $error("reply word carries an invalid verb");

  a_echo_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_kind == tsn_pkg::KIND_REPLY && out_verb == tsn_pkg::DO &&
      out_option == tsn_pkg::OPT_ECHO |-> out_echo == 1'b0)
    else $error("will echo did not clear local echo");

endmodule
`default_nettype wire

/* dv/tb_telnet_stream_negotiator_unit.sv */
// self-checking testbench for the telnet stream negotiator: directed table, then random byte streams
module tb_telnet_stream_negotiator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tsn_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int BYTES_PER_LEG  = 300;
  localparam int LEGS           = 6;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 4;

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_CMD,
    PARSE_SUB,
    PARSE_SUB_IAC
  } parse_phase_e;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_BUSY,
    SINK_PATTERN,
    SINK_CHOKED
  } sink_mode_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] disp;
    logic [7:0] verb;
    logic [7:0] opt;
    logic       echo;
  } nego_word_t;

  // pinned rows carry a hand-written word that replaces the prediction
  typedef struct packed {
    logic [7:0] rx;
    logic       pinned;
    logic       produces;
    nego_word_t res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'h00;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic [1:0]           m_tuser;

  dir_row_t             pin_row = '0;

  // predictor state
  parse_phase_e         parse_phase = PARSE_IDLE;
  logic [1:0]           cmd_count = 2'd1;
  logic [7:0]           held_verb = 8'h00;
  logic [7:0]           held_opt = 8'h00;
  logic                 echo_flag = 1'b1;

  nego_word_t           pending_words[$];
  dir_row_t             dir_rows[$];

  int                   cycles = 0;
  int                   bytes_sent = 0;
  int                   bytes_taken = 0;
  int                   words_checked = 0;
  int                   mismatch_cnt = 0;
  int                   kind_seen[4] = '{0, 0, 0, 0};
  int                   burst_left = 0;
  bit                   idle_on = 1'b1;
  sink_mode_e           sink_mode = SINK_OPEN;
  int                   hold_req = 0;
  int                   hold_seen = 0;
  int                   hold_left = 0;
  logic [15:0]          sink_pat = 16'b1011_0011_1000_1101;

  telnet_stream_negotiator_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // answer to a finished command or subnegotiation
  function automatic bit reply_for(output nego_word_t w);
    w = '0;
    w.kind = KIND_REPLY;
    w.opt = held_opt;
    case (held_verb)
      DO: begin
        if (held_opt == OPT_NAWS) begin
          w.kind = KIND_NAWS;
          w.opt = 8'h00;
        end else if (held_opt == OPT_TTYPE || held_opt == OPT_BINARY) begin
          w.verb = WILL;
        end else begin
          w.verb = WONT;
        end
      end
      WILL: begin
        if (held_opt == OPT_ECHO) echo_flag = 1'b0;
        w.verb = DO;
      end
      WONT: begin
        if (held_opt == OPT_ECHO) echo_flag = 1'b1;
        w.verb = DONT;
      end
      DONT: begin
        w.verb = WONT;
      end
      SB: begin
        if (held_opt != OPT_TTYPE) return 1'b0;
        w.kind = KIND_TTYPE;
        w.opt = 8'h00;
      end
      default: begin
        return 1'b0;
      end
    endcase
    w.echo = echo_flag;
    return 1'b1;
  endfunction

  function automatic bit negotiate_byte(input logic [7:0] b, output nego_word_t w);
    w = '0;
    w.kind = KIND_DISPLAY;
    w.echo = echo_flag;
    case (parse_phase)
      PARSE_IDLE: begin
        if (b == IAC) begin
          parse_phase = PARSE_CMD;
          cmd_count = 2'd1;
          return 1'b0;
        end
        w.disp = b;
        return 1'b1;
      end
      PARSE_CMD: begin
        if (cmd_count == 2'd1) begin
          held_verb = b;
          if (b == IAC) begin
            parse_phase = PARSE_IDLE;
            w.disp = IAC;
            return 1'b1;
          end
          if (b >= NOP && b <= GA) begin
            parse_phase = PARSE_IDLE;
            return 1'b0;
          end
          if (b == SB) parse_phase = PARSE_SUB;
          cmd_count = 2'd2;
          return 1'b0;
        end
        held_opt = b;
        cmd_count = 2'd3;
        parse_phase = PARSE_IDLE;
        return reply_for(w);
      end
      PARSE_SUB: begin
        if (cmd_count == 2'd2) held_opt = b;
        if (cmd_count != 2'd3) cmd_count = cmd_count + 2'd1;
        if (b == IAC) parse_phase = PARSE_SUB_IAC;
        return 1'b0;
      end
      default: begin
        if (b == SE) begin
          parse_phase = PARSE_IDLE;
          return reply_for(w);
        end
        // anything but SE after IAC drops back into the body
        if (cmd_count != 2'd3) cmd_count = cmd_count + 2'd1;
        parse_phase = PARSE_SUB;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic dir_row_t loose(input logic [7:0] b);
    dir_row_t r;
    r = '0;
    r.rx = b;
    return r;
  endfunction

  function automatic dir_row_t silent(input logic [7:0] b);
    dir_row_t r;
    r = loose(b);
    r.pinned = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t shown(input logic [7:0] b, input logic echo);
    dir_row_t r;
    r = silent(b);
    r.produces = 1'b1;
    r.res.kind = KIND_DISPLAY;
    r.res.disp = (b == IAC) ? IAC : b;
    r.res.echo = echo;
    return r;
  endfunction

  function automatic dir_row_t replied(input logic [7:0] b, input logic [7:0] verb,
                                       input logic echo);
    dir_row_t r;
    r = silent(b);
    r.produces = 1'b1;
    r.res.kind = KIND_REPLY;
    r.res.verb = verb;
    r.res.opt = b;
    r.res.echo = echo;
    return r;
  endfunction

  function automatic dir_row_t reported(input logic [7:0] b, input logic [1:0] kind,
                                        input logic echo);
    dir_row_t r;
    r = silent(b);
    r.produces = 1'b1;
    r.res.kind = kind;
    r.res.echo = echo;
    return r;
  endfunction

  // offer one byte and wait until it is taken; bursts with random gaps between them when idle_on is set
  task automatic send_byte(input logic [7:0] b, input dir_row_t pin);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if (idle_on) gap = $urandom_range(1, 7);
    end
    burst_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    pin_row <= pin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_byte(b, '0);
  endtask

  // stop offering until every predicted word has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_sequence();
    int pick;
    int n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_plain(8'($urandom_range(0, 254)));
    end else if (pick < 35) begin
      send_plain(IAC);
      send_plain(IAC);
    end else if (pick < 42) begin
      send_plain(IAC);
      send_plain(8'($urandom_range(NOP, GA)));
    end else if (pick < 72) begin
      send_plain(IAC);
      send_plain(8'(WILL + $urandom_range(0, 3)));
      case ($urandom_range(0, 5))
        0: b = OPT_BINARY;
        1: b = OPT_ECHO;
        2: b = OPT_TTYPE;
        3: b = OPT_NAWS;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_plain(b);
    end else if (pick < 78) begin
      // verb outside the known set still eats an option byte
      send_plain(IAC);
      send_plain($urandom_range(0, 1) ? SE : 8'($urandom_range(0, 239)));
      send_plain(8'($urandom_range(0, 255)));
    end else if (pick < 92) begin
      send_plain(IAC);
      send_plain(SB);
      send_plain($urandom_range(0, 1) ? OPT_TTYPE : 8'($urandom_range(0, 255)));
      n = $urandom_range(0, 5);
      repeat (n) begin
        if ($urandom_range(0, 5) == 0) begin
          send_plain(IAC);
          b = 8'($urandom_range(0, 255));
          send_plain((b == SE) ? IAC : b);
        end else begin
          send_plain(8'($urandom_range(0, 254)));
        end
      end
      send_plain(IAC);
      send_plain(SE);
    end else if (pick < 95) begin
      send_plain(IAC);
      send_plain(SB);
      send_plain(IAC);
      send_plain(SE);
    end else begin
      // noise: stray IACs and broken sequences
      n = $urandom_range(1, 4);
      repeat (n) send_plain(8'($urandom_range(0, 255)));
    end
  endtask

  // predict on every byte the block takes
  always @(posedge clk) begin
    nego_word_t w;
    bit has;
    if (!rst && s_tvalid && s_tready) begin
      has = negotiate_byte(s_tdata, w);
      if (pin_row.pinned) begin
        has = pin_row.produces;
        w = pin_row.res;
      end
      if (has) pending_words.push_back(w);
      bytes_taken++;
    end
  end

  // check every word the block hands out
  always @(posedge clk) begin
    nego_word_t got;
    nego_word_t want;
    logic [TDATA_W-26:0] fill;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser;
      got.disp = m_tdata[7:0];
      got.verb = m_tdata[15:8];
      got.opt = m_tdata[23:16];
      got.echo = m_tdata[24];
      fill = m_tdata[TDATA_W-1:25];
      if (pending_words.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected word: kind %0d byte %h verb %h opt %h echo %b",
                   got.kind, got.disp, got.verb, got.opt, got.echo);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        kind_seen[got.kind]++;
        if (got !== want || fill !== '0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $write("word %0d: expected kind %0d byte %h verb %h opt %h echo %b, ",
                   words_checked, want.kind, want.disp, want.verb, want.opt, want.echo);
            $display("got kind %0d byte %h verb %h opt %h echo %b fill %h",
                     got.kind, got.disp, got.verb, got.opt, got.echo, fill);
          end
        end
      end
    end
  end

  // receiver: long hold-off on request, otherwise a stall pattern per mode
  always @(posedge clk) begin
    sink_pat <= {sink_pat[14:0], sink_pat[15]};
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_OPEN:    m_tready <= 1'b1;
        SINK_BUSY:    m_tready <= ($urandom_range(0, 3) != 0);
        SINK_PATTERN: m_tready <= sink_pat[0];
        default:      m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycles,
               pending_words.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int target;
    dir_rows = '{
      shown(8'h00, 1'b1),
      shown(8'hFE, 1'b1),
      silent(IAC), shown(IAC, 1'b1),
      silent(IAC), silent(NOP),
      silent(IAC), silent(DO), reported(OPT_NAWS, KIND_NAWS, 1'b1),
      silent(IAC), silent(WILL), replied(OPT_ECHO, DO, 1'b0),
      silent(IAC), silent(WONT), replied(OPT_ECHO, DONT, 1'b1),
      silent(IAC), silent(DONT), replied(8'hFF, WONT, 1'b1),
      silent(IAC), loose(8'h00), silent(8'h7F),
      silent(IAC), loose(SB), loose(OPT_TTYPE), loose(8'h41),
      silent(IAC), loose(8'h41), silent(IAC), reported(SE, KIND_TTYPE, 1'b1),
      silent(IAC), loose(SB), silent(IAC), silent(SE)
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    idle_on = 1'b0;
    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i]);
    settle();

    for (int leg = 0; leg < LEGS; leg++) begin
      sink_mode = sink_mode_e'(leg % 4);
      idle_on = (leg % 3 != 1);
      // receiver holds off while bytes keep coming, so the block backs up
      if (leg == 2) hold_req++;
      target = bytes_sent + BYTES_PER_LEG;
      while (bytes_sent < target) send_sequence();
      if (leg == 3) settle();
    end
    settle();

    $write("sent %0d bytes (%0d taken), checked %0d words: ",
           bytes_sent, bytes_taken, words_checked);
    $display("%0d display, %0d reply, %0d window size, %0d terminal type",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("included a %0d-cycle receiver hold-off and sender pauses until drained",
             LONG_HOLD);
    if (mismatch_cnt == 0 && pending_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatch_cnt,
               pending_words.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
